// ===== hw/rtl/daily_alarm_schedule_table_macros.svh =====
// Assertion macros used by the alarm table datapath.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef DAILY_ALARM_SCHEDULE_TABLE_MACROS_SVH
`define DAILY_ALARM_SCHEDULE_TABLE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DAST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define DAST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dast_pkg.sv =====
// Shared types and constants of the daily alarm schedule table.
// No dependencies; used by the controller, datapath and top level.
package dast_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_INDEX_W = 4;
	localparam int IDX_CMP_W = (CNT_W > ENTRY_INDEX_W) ? CNT_W : ENTRY_INDEX_W;
	localparam int FIRED_ENTRY_W = 3;
	localparam int ENTRY_COUNT_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_BAD_TIME  = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_THR  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_THR = 1'd1;

	localparam logic [CFG_DATA_W-1:0] THR_RESET = 7'd20;
	localparam logic [4:0] LAST_HOUR   = 5'd23;
	localparam logic [5:0] LAST_MINUTE = 6'd59;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic       enabled;
		logic       fired;
		logic [4:0] last_day;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_done;
	} dp_stat_t;

endpackage

// ===== hw/rtl/dast_ctrl.sv =====
// Sequencer of the alarm table: load, walk the entries, finish.
// Depends on dast_pkg for the command and status structs.
module dast_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dast_pkg::dp_stat_t  stat,
	output dast_pkg::ctl_cmd_t  cmd,
	output logic                busy
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_WALK;
			end
			S_WALK: begin
				if (stat.walk_done) state_d = S_FINISH;
			end
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.step   = (state_q == S_WALK) && !stat.walk_done;
	assign cmd.finish = (state_q == S_FINISH);
	assign busy       = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/dast_datapath.sv =====
// Entry store, walk pointer, per-entry update logic and result registers.
// Depends on dast_pkg and daily_alarm_schedule_table_macros.svh.
`include "daily_alarm_schedule_table_macros.svh"

module dast_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dast_pkg::ctl_cmd_t                    cmd,
	output dast_pkg::dp_stat_t                    stat,
	input  logic [1:0]                            action,
	input  logic [4:0]                            hour_value,
	input  logic [5:0]                            minute_value,
	input  logic [4:0]                            day_of_month,
	input  logic [6:0]                            supply_level,
	input  logic [6:0]                            battery_percent,
	input  logic                                  enable_flag,
	input  logic [dast_pkg::ENTRY_INDEX_W-1:0]    entry_index,
	input  logic                                  cfg_we,
	input  logic [dast_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dast_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output logic                                  done,
	output logic                                  fired,
	output logic [dast_pkg::FIRED_ENTRY_W-1:0]    fired_entry,
	output logic [2:0]                            status,
	output logic [dast_pkg::ENTRY_COUNT_W-1:0]    entry_count
);

	dast_pkg::entry_t entry_q [dast_pkg::MAX_ENTRIES];

	logic [dast_pkg::CFG_DATA_W-1:0] supply_thr_q;
	logic [dast_pkg::CFG_DATA_W-1:0] battery_thr_q;

	// latched request
	logic [1:0] act_q;
	logic [4:0] hr_q;
	logic [5:0] mn_q;
	logic [4:0] day_q;
	logic       en_q;
	logic       lvl_ok_q;
	logic       bad_idx_q;

	logic [dast_pkg::CNT_W-1:0] ptr_q;
	logic [dast_pkg::CNT_W-1:0] limit_q;
	logic [dast_pkg::CNT_W-1:0] used_q;
	logic                       dup_q;
	logic                       hit_q;
	logic [dast_pkg::IDX_W-1:0] which_q;

	logic                                 done_q;
	logic                                 fired_q;
	logic [dast_pkg::FIRED_ENTRY_W-1:0]   fired_entry_q;
	logic [2:0]                           status_q;
	logic [dast_pkg::ENTRY_COUNT_W-1:0]   entry_count_q;

	logic [dast_pkg::IDX_W-1:0] ptr_idx;
	logic [dast_pkg::IDX_W-1:0] rd_addr;
	dast_pkg::entry_t           rd_entry;
	dast_pkg::entry_t           tick_entry;
	logic                       tick_fire;
	logic                       time_hit;
	logic                       walk_done;

	logic                       idx_in_range;
	logic                       add_ok;
	logic [2:0]                 fin_status;
	logic [dast_pkg::CNT_W-1:0] fin_used;

	logic                       wr_en;
	logic [dast_pkg::IDX_W-1:0] wr_addr;
	dast_pkg::entry_t           wr_data;

	assign walk_done      = !(ptr_q < limit_q);
	assign stat.walk_done = walk_done;

	assign ptr_idx = dast_pkg::IDX_W'(ptr_q);
	// remove copies the next entry down into the current slot
	assign rd_addr = (act_q == dast_pkg::ACT_REMOVE) ?
		dast_pkg::IDX_W'(ptr_q + dast_pkg::CNT_W'(1)) : ptr_idx;
	assign rd_entry = entry_q[rd_addr];

	assign time_hit = (rd_entry.hour == hr_q) && (rd_entry.minute == mn_q);

	always_comb begin
		tick_fire = rd_entry.enabled && time_hit &&
			(!rd_entry.fired || (rd_entry.last_day != day_q)) && lvl_ok_q;
		tick_entry = rd_entry;
		if (tick_fire) begin
			tick_entry.fired    = 1'b1;
			tick_entry.last_day = day_q;
		end
		// new day: re-arm
		if (tick_entry.last_day != day_q) tick_entry.fired = 1'b0;
	end

	assign idx_in_range = dast_pkg::IDX_CMP_W'(entry_index) < dast_pkg::IDX_CMP_W'(used_q);

	always_comb begin
		fin_status = dast_pkg::ST_OK;
		fin_used   = used_q;
		add_ok     = 1'b0;
		case (act_q)
			dast_pkg::ACT_ADD: begin
				if (dup_q) begin
					fin_status = dast_pkg::ST_DUPLICATE;
				end else if (used_q >= dast_pkg::CNT_W'(dast_pkg::MAX_ENTRIES)) begin
					fin_status = dast_pkg::ST_FULL;
				end else if (hr_q > dast_pkg::LAST_HOUR || mn_q > dast_pkg::LAST_MINUTE) begin
					fin_status = dast_pkg::ST_BAD_TIME;
				end else begin
					add_ok   = 1'b1;
					fin_used = used_q + dast_pkg::CNT_W'(1);
				end
			end
			dast_pkg::ACT_REMOVE: begin
				if (bad_idx_q) begin
					fin_status = dast_pkg::ST_BAD_INDEX;
				end else begin
					fin_used = used_q - dast_pkg::CNT_W'(1);
				end
			end
			dast_pkg::ACT_CLEAR: fin_used = '0;
			default: fin_used = used_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_idx;
		wr_data = rd_entry;
		if (cmd.step && act_q == dast_pkg::ACT_TICK) begin
			wr_en   = 1'b1;
			wr_data = tick_entry;
		end else if (cmd.step && act_q == dast_pkg::ACT_REMOVE) begin
			wr_en   = 1'b1;
		end else if (cmd.finish && add_ok) begin
			wr_en            = 1'b1;
			wr_addr          = dast_pkg::IDX_W'(used_q);
			wr_data.hour     = hr_q;
			wr_data.minute   = mn_q;
			wr_data.enabled  = en_q;
			wr_data.fired    = 1'b0;
			wr_data.last_day = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) entry_q[wr_addr] <= wr_data;
	end

	// request latch, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			hr_q     <= hour_value;
			mn_q     <= minute_value;
			day_q    <= day_of_month;
			en_q     <= enable_flag;
			lvl_ok_q <= (supply_level > supply_thr_q) && (battery_percent > battery_thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_thr_q  <= dast_pkg::THR_RESET;
			battery_thr_q <= dast_pkg::THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dast_pkg::REG_SUPPLY_THR:  supply_thr_q  <= cfg_wdata;
				dast_pkg::REG_BATTERY_THR: battery_thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			limit_q   <= '0;
			used_q    <= '0;
			dup_q     <= 1'b0;
			hit_q     <= 1'b0;
			which_q   <= '0;
			bad_idx_q <= 1'b0;
		end else if (cmd.load) begin
			dup_q     <= 1'b0;
			hit_q     <= 1'b0;
			which_q   <= '0;
			bad_idx_q <= 1'b0;
			ptr_q     <= '0;
			limit_q   <= '0;
			case (action) inside
				dast_pkg::ACT_TICK, dast_pkg::ACT_ADD: limit_q <= used_q;
				dast_pkg::ACT_REMOVE: begin
					if (idx_in_range) begin
						ptr_q   <= dast_pkg::CNT_W'(entry_index);
						limit_q <= used_q - dast_pkg::CNT_W'(1);
					end else begin
						bad_idx_q <= 1'b1;
					end
				end
				default: limit_q <= '0;
			endcase
		end else if (cmd.step) begin
			ptr_q <= ptr_q + dast_pkg::CNT_W'(1);
			if (act_q == dast_pkg::ACT_ADD && time_hit) dup_q <= 1'b1;
			if (act_q == dast_pkg::ACT_TICK && tick_fire && !hit_q) begin
				hit_q   <= 1'b1;
				which_q <= ptr_idx;
			end
		end else if (cmd.finish) begin
			used_q <= fin_used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			fired_q       <= hit_q;
			fired_entry_q <= dast_pkg::FIRED_ENTRY_W'(which_q);
			status_q      <= fin_status;
			entry_count_q <= dast_pkg::ENTRY_COUNT_W'(fin_used);
		end
	end

	assign done        = done_q;
	assign fired       = fired_q;
	assign fired_entry = fired_entry_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	`DAST_ASSERT_IMP(a_used_bound, 1'b1, used_q <= dast_pkg::CNT_W'(dast_pkg::MAX_ENTRIES), "entry count above table size")
	`DAST_ASSERT_IMP(a_ptr_bound, 1'b1, ptr_q <= limit_q, "walk pointer passed its limit")
	`DAST_ASSERT_IMP(a_step_in_walk, cmd.step, !walk_done, "step issued after walk ended")
	`DAST_ASSERT_IMP(a_hit_only_tick, hit_q, act_q == dast_pkg::ACT_TICK, "hit flag set outside a tick")
	`DAST_ASSERT_IMP(a_fire_status_ok, done_q && fired_q, status_q == dast_pkg::ST_OK, "fired result with error status")

endmodule

// ===== hw/rtl/daily_alarm_schedule_table.sv =====
// Daily alarm schedule table: up to dast_pkg::MAX_ENTRIES daily alarms.
// A request is taken when start is high and busy is low. action selects tick
// check, add, remove or clear; the remaining fields carry the time, day,
// levels, enable bit and entry position for that request.
// Every request yields one result: done is high for exactly one cycle with
// fired, fired_entry, status and entry_count valid in that cycle. The
// receiver cannot stall, so each result must be taken when shown.
// The walk covers the used entries for tick and add, the entries above the
// removed slot for remove, and none for clear or a bad index. busy drops in
// the same cycle as done rises, so a new request is taken only once the last
// result is shown. The walk reads one entry a cycle; tick and remove rewrite it.
// Thresholds are written through cfg_we/cfg_index/cfg_wdata while idle; the
// user must keep to this, as the block itself does not enforce it.
// Reset empties the table and sets both thresholds to 20; no clearing pass.
// Depends on dast_pkg, dast_ctrl and dast_datapath.
module daily_alarm_schedule_table (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            action,
	input  logic [4:0]                            hour_value,
	input  logic [5:0]                            minute_value,
	input  logic [4:0]                            day_of_month,
	input  logic [6:0]                            supply_level,
	input  logic [6:0]                            battery_percent,
	input  logic                                  enable_flag,
	input  logic [dast_pkg::ENTRY_INDEX_W-1:0]    entry_index,
	input  logic                                  cfg_we,
	input  logic [dast_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dast_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output logic                                  done,
	output logic                                  fired,
	output logic [dast_pkg::FIRED_ENTRY_W-1:0]    fired_entry,
	output logic [2:0]                            status,
	output logic [dast_pkg::ENTRY_COUNT_W-1:0]    entry_count
);

	dast_pkg::ctl_cmd_t cmd;
	dast_pkg::dp_stat_t stat;

	dast_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dast_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (action),
		.hour_value      (hour_value),
		.minute_value    (minute_value),
		.day_of_month    (day_of_month),
		.supply_level    (supply_level),
		.battery_percent (battery_percent),
		.enable_flag     (enable_flag),
		.entry_index     (entry_index),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.fired           (fired),
		.fired_entry     (fired_entry),
		.status          (status),
		.entry_count     (entry_count)
	);

endmodule

// ===== bench/tb_top.sv =====
// Testbench for daily_alarm_schedule_table: directed table edits and ticks, then
// random phases under several threshold settings, all checked by a scoreboard.
// Depends on dast_pkg and the daily_alarm_schedule_table RTL.
module tb_top;
	import dast_pkg::*;

	typedef struct {
		logic [1:0]               action;
		logic [4:0]               hour;
		logic [5:0]               minute;
		logic [4:0]               day;
		logic [6:0]               supply;
		logic [6:0]               battery;
		logic                     enable;
		logic [ENTRY_INDEX_W-1:0] index;
	} alarm_request_t;

	typedef struct {
		logic                     fired;
		logic [FIRED_ENTRY_W-1:0] fired_entry;
		logic [2:0]               status;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} alarm_outcome_t;

	class alarm_scoreboard;
		entry_t         entries [MAX_ENTRIES];
		int             used;
		logic [6:0]     supply_thr;
		logic [6:0]     battery_thr;
		alarm_outcome_t expected_outcomes [$];
		int             mismatch_count;

		function new();
			used = 0;
			supply_thr = THR_RESET;
			battery_thr = THR_RESET;
			mismatch_count = 0;
		endfunction

		function int pending();
			return expected_outcomes.size();
		endfunction

		// updates the table copy and returns what the block should answer
		function alarm_outcome_t apply_request(alarm_request_t r);
			alarm_outcome_t o;
			bit levels_ok;
			bit dup;
			o = '{fired: 1'b0, fired_entry: '0, status: ST_OK, entry_count: '0};
			case (r.action)
				ACT_TICK: begin
					levels_ok = (r.supply > supply_thr) && (r.battery > battery_thr);
					for (int i = 0; i < used; i++) begin
						if (entries[i].enabled && entries[i].hour == r.hour &&
						    entries[i].minute == r.minute && levels_ok &&
						    (!entries[i].fired || entries[i].last_day != r.day)) begin
							if (!o.fired) begin
								o.fired = 1'b1;
								o.fired_entry = FIRED_ENTRY_W'(i);
							end
							entries[i].fired = 1'b1;
							entries[i].last_day = r.day;
						end
						// new day: re-arm
						if (entries[i].last_day != r.day)
							entries[i].fired = 1'b0;
					end
				end
				ACT_ADD: begin
					dup = 1'b0;
					for (int i = 0; i < used; i++)
						if (entries[i].hour == r.hour && entries[i].minute == r.minute)
							dup = 1'b1;
					if (dup)
						o.status = ST_DUPLICATE;
					else if (used >= MAX_ENTRIES)
						o.status = ST_FULL;
					else if (r.hour > LAST_HOUR || r.minute > LAST_MINUTE)
						o.status = ST_BAD_TIME;
					else begin
						entries[used] = '{hour: r.hour, minute: r.minute, enabled: r.enable,
							fired: 1'b0, last_day: 5'd0};
						used++;
					end
				end
				ACT_REMOVE: begin
					if (int'(r.index) >= used)
						o.status = ST_BAD_INDEX;
					else begin
						for (int i = int'(r.index); i < used - 1; i++)
							entries[i] = entries[i + 1];
						used--;
					end
				end
				default: used = 0;
			endcase
			o.entry_count = ENTRY_COUNT_W'(used);
			return o;
		endfunction

		function void note_request(alarm_request_t r);
			expected_outcomes.push_back(apply_request(r));
		endfunction

		function void check_result(alarm_outcome_t got);
			alarm_outcome_t exp_o;
			if (expected_outcomes.size() == 0) begin
				if (mismatch_count < 10)
					$display("ERROR: result with no request pending");
				mismatch_count++;
				return;
			end
			exp_o = expected_outcomes.pop_front();
			if (got.fired !== exp_o.fired || got.fired_entry !== exp_o.fired_entry ||
			    got.status !== exp_o.status || got.entry_count !== exp_o.entry_count) begin
				if (mismatch_count < 10)
					$display("ERROR: fired/entry/status/count expected %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
						exp_o.fired, exp_o.fired_entry, exp_o.status, exp_o.entry_count,
						got.fired, got.fired_entry, got.status, got.entry_count);
				mismatch_count++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               action;
	logic [4:0]               hour_value;
	logic [5:0]               minute_value;
	logic [4:0]               day_of_month;
	logic [6:0]               supply_level;
	logic [6:0]               battery_percent;
	logic                     enable_flag;
	logic [ENTRY_INDEX_W-1:0] entry_index;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_wdata;
	logic                     done;
	logic                     fired;
	logic [FIRED_ENTRY_W-1:0] fired_entry;
	logic [2:0]               status;
	logic [ENTRY_COUNT_W-1:0] entry_count;

	alarm_scoreboard sb = new();
	logic [4:0]      today = 5'd1;
	bit              quiet = 1'b0;

	daily_alarm_schedule_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.hour_value      (hour_value),
		.minute_value    (minute_value),
		.day_of_month    (day_of_month),
		.supply_level    (supply_level),
		.battery_percent (battery_percent),
		.enable_flag     (enable_flag),
		.entry_index     (entry_index),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.fired           (fired),
		.fired_entry     (fired_entry),
		.status          (status),
		.entry_count     (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(alarm_outcome_t'{fired, fired_entry, status, entry_count});
	end

	function automatic alarm_request_t mk(logic [1:0] act, logic [4:0] hr, logic [5:0] mn,
		logic [4:0] day, logic [6:0] sup, logic [6:0] bat, logic en, logic [3:0] idx);
		alarm_request_t r;
		r = '{action: act, hour: hr, minute: mn, day: day, supply: sup, battery: bat,
			enable: en, index: idx};
		return r;
	endfunction

	function automatic logic [6:0] level_above(logic [6:0] thr);
		if (thr == 7'd127)
			return 7'd127;
		return 7'($urandom_range(int'(thr) + 1, 127));
	endfunction

	// mostly well-formed traffic: ticks at stored times, valid adds, in-range removes
	function automatic alarm_request_t make_random_request();
		alarm_request_t r;
		int pick;
		int sel;
		int j;
		r = mk(ACT_TICK, 5'($urandom), 6'($urandom), 5'($urandom), 7'($urandom),
			7'($urandom), 1'($urandom), 4'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			r.action = ACT_TICK;
			if ($urandom_range(0, 9) < 7 && sb.used > 0) begin
				j = $urandom_range(0, sb.used - 1);
				r.hour = sb.entries[j].hour;
				r.minute = sb.entries[j].minute;
			end
			if ($urandom_range(0, 19) == 0)
				today = 5'($urandom_range(0, 31));
			else if ($urandom_range(0, 3) == 0)
				today = (today >= 5'd31) ? 5'd1 : today + 5'd1;
			r.day = today;
			if ($urandom_range(0, 4) != 0) begin
				r.supply = level_above(sb.supply_thr);
				r.battery = level_above(sb.battery_thr);
			end
		end else if (pick < 80) begin
			r.action = ACT_ADD;
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				r.hour = 5'($urandom_range(0, 23));
				r.minute = 6'($urandom_range(0, 59));
			end else if (sel < 8 && sb.used > 0) begin
				j = $urandom_range(0, sb.used - 1);
				r.hour = sb.entries[j].hour;
				r.minute = sb.entries[j].minute;
			end else if (sel == 8)
				r.hour = 5'($urandom_range(24, 31));
			else
				r.minute = 6'($urandom_range(60, 63));
		end else if (pick < 96) begin
			r.action = ACT_REMOVE;
			if ($urandom_range(0, 4) != 0 && sb.used > 0)
				r.index = 4'($urandom_range(0, sb.used - 1));
		end else
			r.action = ACT_CLEAR;
		return r;
	endfunction

	task automatic issue(alarm_request_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= r.action;
		hour_value <= r.hour;
		minute_value <= r.minute;
		day_of_month <= r.day;
		supply_level <= r.supply;
		battery_percent <= r.battery;
		enable_flag <= r.enable;
		entry_index <= r.index;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(r);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_thresholds(logic [6:0] sup, logic [6:0] bat);
		cfg_we <= 1'b1;
		cfg_index <= REG_SUPPLY_THR;
		cfg_wdata <= sup;
		@(posedge clk);
		cfg_index <= REG_BATTERY_THR;
		cfg_wdata <= bat;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.supply_thr = sup;
		sb.battery_thr = bat;
	endtask

	initial begin
		logic [6:0] thr_sup [8];
		logic [6:0] thr_bat [8];
		int         phase_len;
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_TICK;
		hour_value <= '0;
		minute_value <= '0;
		day_of_month <= '0;
		supply_level <= '0;
		battery_percent <= '0;
		enable_flag <= 1'b0;
		entry_index <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SUPPLY_THR;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset thresholds of 20
		issue(mk(ACT_TICK, 5'd0, 6'd0, 5'd0, 7'd127, 7'd127, 1'b0, 4'd0));
		issue(mk(ACT_ADD, 5'd0, 6'd0, 5'd0, 7'd0, 7'd0, 1'b1, 4'd0));
		issue(mk(ACT_ADD, 5'd23, 6'd59, 5'd0, 7'd0, 7'd0, 1'b1, 4'd0));
		issue(mk(ACT_ADD, 5'd23, 6'd59, 5'd0, 7'd0, 7'd0, 1'b0, 4'd0));
		issue(mk(ACT_ADD, 5'd24, 6'd0, 5'd0, 7'd0, 7'd0, 1'b1, 4'd0));
		issue(mk(ACT_ADD, 5'd0, 6'd60, 5'd0, 7'd0, 7'd0, 1'b1, 4'd0));
		issue(mk(ACT_ADD, 5'd31, 6'd63, 5'd31, 7'd127, 7'd127, 1'b1, 4'd15));
		issue(mk(ACT_ADD, 5'd12, 6'd30, 5'd0, 7'd0, 7'd0, 1'b0, 4'd0));
		// day zero matches the last day of a fresh entry
		issue(mk(ACT_TICK, 5'd0, 6'd0, 5'd0, 7'd100, 7'd100, 1'b0, 4'd0));
		issue(mk(ACT_TICK, 5'd0, 6'd0, 5'd0, 7'd100, 7'd100, 1'b0, 4'd0));
		issue(mk(ACT_TICK, 5'd0, 6'd0, 5'd1, 7'd100, 7'd100, 1'b0, 4'd0));
		// levels must be strictly above the thresholds
		issue(mk(ACT_TICK, 5'd23, 6'd59, 5'd1, 7'd20, 7'd100, 1'b0, 4'd0));
		issue(mk(ACT_TICK, 5'd23, 6'd59, 5'd1, 7'd21, 7'd20, 1'b0, 4'd0));
		issue(mk(ACT_TICK, 5'd23, 6'd59, 5'd1, 7'd21, 7'd21, 1'b0, 4'd0));
		issue(mk(ACT_TICK, 5'd12, 6'd30, 5'd1, 7'd127, 7'd127, 1'b0, 4'd0));
		for (int h = 1; h <= 5; h++)
			issue(mk(ACT_ADD, 5'(h), 6'd0, 5'd0, 7'd0, 7'd0, 1'b1, 4'd0));
		// full table: duplicate wins over full, full wins over bad time
		issue(mk(ACT_ADD, 5'd6, 6'd0, 5'd0, 7'd0, 7'd0, 1'b1, 4'd0));
		issue(mk(ACT_ADD, 5'd0, 6'd0, 5'd0, 7'd0, 7'd0, 1'b1, 4'd0));
		issue(mk(ACT_ADD, 5'd24, 6'd0, 5'd0, 7'd0, 7'd0, 1'b1, 4'd0));
		issue(mk(ACT_REMOVE, 5'd0, 6'd0, 5'd0, 7'd0, 7'd0, 1'b0, 4'd15));
		issue(mk(ACT_REMOVE, 5'd0, 6'd0, 5'd0, 7'd0, 7'd0, 1'b0, 4'd0));
		issue(mk(ACT_REMOVE, 5'd0, 6'd0, 5'd0, 7'd0, 7'd0, 1'b0, 4'd6));
		issue(mk(ACT_CLEAR, 5'd0, 6'd0, 5'd0, 7'd0, 7'd0, 1'b0, 4'd0));
		issue(mk(ACT_REMOVE, 5'd0, 6'd0, 5'd0, 7'd0, 7'd0, 1'b0, 4'd0));
		drain();

		thr_sup = '{7'd0, 7'd100, 7'd0, 7'd100, 7'd127, 7'd20, 7'd0, 7'd0};
		thr_bat = '{7'd0, 7'd100, 7'd100, 7'd0, 7'd127, 7'd20, 7'd0, 7'd0};
		for (int p = 0; p < 8; p++) begin
			if (p >= 6) begin
				thr_sup[p] = 7'($urandom_range(0, 100));
				thr_bat[p] = 7'($urandom_range(0, 100));
			end
			write_thresholds(thr_sup[p], thr_bat[p]);
			phase_len = (thr_sup[p] == 7'd127) ? 100 : 215;
			for (int n = 0; n < phase_len; n++) begin
				if (n % 40 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				issue(make_random_request());
			end
			quiet = 1'b0;
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
